>>> rtl/core/dltq_pkg.sv
// Package with command, status codes and internal types of the timer queue.
package dltq_pkg;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int PERIOD_W = 16;
  localparam int HANDLE_W = 8;
  localparam int TAG_W = 16;
  localparam int DELTA_W = 17;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_PERIOD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Classified operation handed from the front part to the back part.
  typedef enum logic [3:0] {
    OP_ADD    = 4'b0001,
    OP_REMOVE = 4'b0010,
    OP_TICK   = 4'b0100,
    OP_DONE   = 4'b1000
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [STATUS_W-1:0]   status;
    logic [PERIOD_W-1:0]   period;
    logic                  one_shot;
    logic [HANDLE_W-1:0]   handle;
    logic [TAG_W-1:0]      tag;
  } job_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [HANDLE_W-1:0] fired_handle;
    logic [TAG_W-1:0]    fired_tag;
  } res_t;
endpackage

>>> rtl/core/dltq_cmd_if.sv
// Valid/ready channels for command beats and result beats.
interface dltq_cmd_if import dltq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [PERIOD_W-1:0] period_ticks;
  logic                one_shot;
  logic [HANDLE_W-1:0] timer_handle;
  logic [TAG_W-1:0]    callback_tag;
  modport source (output valid, command, period_ticks, one_shot, timer_handle,
                  callback_tag, input ready);
  modport sink (input valid, command, period_ticks, one_shot, timer_handle,
                callback_tag, output ready);
endinterface

interface dltq_res_if import dltq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                fired;
  logic [HANDLE_W-1:0] fired_handle;
  logic [TAG_W-1:0]    fired_tag;
  modport source (output valid, status, fired, fired_handle, fired_tag, input ready);
  modport sink (input valid, status, fired, fired_handle, fired_tag, output ready);
endinterface

>>> rtl/core/dltq_front.sv
// Front part: takes command beats, screens them and queues jobs for the back part.
module dltq_front import dltq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  dltq_cmd_if.sink         cmd,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);
  localparam int QD = 2;

  job_t            q [QD];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      q_count;
  job_t            job_in;
  logic            push, pop;

  assign cmd.ready = (q_count != 2'd2);
  assign push = cmd.valid && cmd.ready;
  assign pop = job_valid && job_ready;
  assign job_valid = (q_count != 2'd0);
  assign job = q[rd_ptr];

  // A zero period is refused here; a full pool is only known when the back
  // part reaches the add, since earlier jobs may still free entries.
  always_comb begin
    job_in.period = cmd.period_ticks;
    job_in.one_shot = cmd.one_shot;
    job_in.handle = cmd.timer_handle;
    job_in.tag = cmd.callback_tag;
    job_in.status = ST_OK;
    job_in.op = OP_DONE;
    unique case (cmd.command)
      CMD_ADD: begin
        if (cmd.period_ticks == '0) job_in.status = ST_ZERO_PERIOD;
        else job_in.op = OP_ADD;
      end
      CMD_REMOVE: job_in.op = OP_REMOVE;
      CMD_TICK: job_in.op = OP_TICK;
      default: job_in.op = OP_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      q_count <= q_count + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> rtl/core/dltq_back.sv
// Back part: walks the linked delta list in pool memories and updates it.
module dltq_back import dltq_pkg::*; #(
  parameter int POOL_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      res_valid,
  input  logic      res_ready,
  output res_t      res
);
  localparam int IW = $clog2(POOL_ENTRIES + 1);
  localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LSUCC  = 11'b00000000010,
    S_LRD    = 11'b00000000100,
    S_LCHK   = 11'b00000001000,
    S_LFIX   = 11'b00000010000,
    S_RRD    = 11'b00000100000,
    S_RCHK   = 11'b00001000000,
    S_RNXT   = 11'b00010000000,
    S_RFIX   = 11'b00100000000,
    S_TRD    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state;
  // Pool memories.
  logic [DELTA_W-1:0]  m_delta  [POOL_ENTRIES];
  logic [PERIOD_W-1:0] m_period [POOL_ENTRIES];
  logic [HANDLE_W-1:0] m_handle [POOL_ENTRIES];
  logic [TAG_W-1:0]    m_tag    [POOL_ENTRIES];
  logic                m_shot   [POOL_ENTRIES];
  logic [IW-1:0]       m_link   [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] in_use;

  logic [IW-1:0]      head;
  logic [DELTA_W-1:0] elapsed;
  // Walk registers.
  logic [IW-1:0]      slot, p, prev, steps;
  logic [DELTA_W-1:0] target, cum, rel, rmv_delta;
  logic [HANDLE_W-1:0] key;
  // Registered read port.
  logic [AW-1:0]      ra;
  logic [DELTA_W-1:0] rd_delta;
  logic [PERIOD_W-1:0] rd_period;
  logic [HANDLE_W-1:0] rd_handle;
  logic [TAG_W-1:0]   rd_tag;
  logic               rd_shot;
  logic [IW-1:0]      rd_link;
  // Single write port per memory.
  logic               we_d, we_l, we_e;
  logic [AW-1:0]      wa_d, wa_l, wa_e;
  logic [DELTA_W-1:0] wd_d;
  logic [IW-1:0]      wd_l;
  logic [AW-1:0]      free_idx;
  logic               pool_full;
  logic [DELTA_W-1:0] sum_d;
  logic [DELTA_W-1:0] elapsed_inc;
  logic [STATUS_W-1:0] st;
  logic               fired;
  logic [HANDLE_W-1:0] fh;
  logic [TAG_W-1:0]   ft;

  always_comb begin
    free_idx = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--)
      if (!in_use[i]) free_idx = AW'(i);
  end

  assign pool_full = &in_use;
  assign sum_d = cum + rd_delta;
  assign elapsed_inc = elapsed + DELTA_W'(1);
  assign job_ready = (state == S_IDLE) && !res_valid;
  assign res = '{status: st, fired: fired, fired_handle: fh, fired_tag: ft};

  always_ff @(posedge clk) begin
    rd_delta <= m_delta[ra];
    rd_period <= m_period[ra];
    rd_handle <= m_handle[ra];
    rd_tag <= m_tag[ra];
    rd_shot <= m_shot[ra];
    rd_link <= m_link[ra];
    if (we_d) m_delta[wa_d] <= wd_d;
    if (we_l) m_link[wa_l] <= wd_l;
    if (we_e) begin
      m_period[wa_e] <= job.period;
      m_handle[wa_e] <= job.handle;
      m_tag[wa_e] <= job.tag;
      m_shot[wa_e] <= job.one_shot;
    end
  end

  always_comb begin
    we_d = 1'b0; wa_d = slot[AW-1:0]; wd_d = rel;
    we_l = 1'b0; wa_l = slot[AW-1:0]; wd_l = p;
    we_e = 1'b0; wa_e = free_idx;
    ra = p[AW-1:0];
    unique case (state)
      S_IDLE: begin
        ra = head[AW-1:0];
        we_e = job_valid && job_ready && job.op == OP_ADD && !pool_full;
      end
      S_LFIX: begin
        // The new entry gets its relative delta and its successor.
        we_d = 1'b1; we_l = 1'b1;
      end
      S_LSUCC: begin
        // The successor loses the new delta; the predecessor points at the new entry.
        we_d = (p < NIL); wa_d = p[AW-1:0]; wd_d = rd_delta - rel;
        we_l = (prev != NIL); wa_l = prev[AW-1:0]; wd_l = slot;
      end
      S_RFIX: begin
        // The successor absorbs the removed delta; the predecessor skips the entry.
        we_d = (p < NIL); wa_d = p[AW-1:0]; wd_d = rd_delta + rmv_delta;
        we_l = (prev != NIL); wa_l = prev[AW-1:0]; wd_l = p;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_use <= '0;
      head <= NIL;
      elapsed <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid && job_ready) begin
          st <= job.status; fired <= 1'b0; fh <= '0; ft <= '0;
          key <= job.handle; prev <= NIL; p <= head; steps <= '0; cum <= '0;
          case (job.op)
            OP_ADD: begin
              if (pool_full) begin
                st <= ST_POOL_FULL;
                state <= S_OUT;
              end else begin
                slot <= IW'(free_idx);
                in_use[free_idx] <= 1'b1;
                target <= DELTA_W'(job.period) + elapsed;
                state <= S_LRD;
              end
            end
            OP_REMOVE: state <= S_RRD;
            OP_TICK: state <= (head == NIL) ? S_OUT : S_TRD;
            default: state <= S_OUT;
          endcase
        end
        // Link walk: p is read in S_LRD, its data is seen in S_LCHK.
        S_LRD: state <= S_LCHK;
        S_LCHK: begin
          if (p < NIL && steps < IW'(POOL_ENTRIES) && sum_d <= target) begin
            cum <= sum_d; prev <= p; p <= rd_link; steps <= steps + IW'(1);
            state <= S_LRD;
          end else begin
            if (p > NIL) p <= NIL;
            rel <= target - cum;
            state <= S_LFIX;
          end
        end
        S_LFIX: state <= S_LSUCC;
        S_LSUCC: begin
          if (prev == NIL) head <= slot;
          state <= S_OUT;
        end
        S_RRD: state <= S_RCHK;
        S_RCHK: begin
          if (p < NIL && steps < IW'(POOL_ENTRIES) && rd_handle != key) begin
            prev <= p; p <= rd_link; steps <= steps + IW'(1);
            state <= S_RRD;
          end else if (p >= NIL || steps >= IW'(POOL_ENTRIES)) begin
            st <= ST_NOT_FOUND;
            state <= S_OUT;
          end else begin
            in_use[p[AW-1:0]] <= 1'b0;
            if (prev == NIL) begin
              // Removing the head restarts the count and keeps later due times.
              head <= rd_link; elapsed <= '0;
              rmv_delta <= rd_delta - elapsed;
            end else begin
              rmv_delta <= rd_delta;
            end
            p <= rd_link;
            state <= S_RNXT;
          end
        end
        // The successor is read here and patched in S_RFIX.
        S_RNXT: state <= S_RFIX;
        S_RFIX: state <= S_OUT;
        S_TRD: begin
          // Head data was read while the job was taken.
          if (elapsed_inc >= rd_delta) begin
            fired <= 1'b1; fh <= rd_handle; ft <= rd_tag;
            elapsed <= '0;
            head <= (rd_link > NIL) ? NIL : rd_link;
            if (rd_shot) begin
              in_use[head[AW-1:0]] <= 1'b0;
              state <= S_OUT;
            end else begin
              slot <= head;
              target <= DELTA_W'(rd_period);
              p <= (rd_link > NIL) ? NIL : rd_link;
              prev <= NIL; cum <= '0; steps <= '0;
              state <= S_LRD;
            end
          end else begin
            elapsed <= elapsed_inc;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/delta_list_timer_queue.sv
// Top level of the delta-list timer queue.
// An add or a remove walks the list and reads one pool entry per step; a tick that
// fires a periodic timer walks the list again to re-insert it. The back part takes one
// job at a time and takes the next only once the result beat has left.
// Reset (rst, synchronous): empties the list, frees the pool and clears the count.
module delta_list_timer_queue import dltq_pkg::*; #(
  parameter int POOL_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst,
  dltq_cmd_if.sink  cmd,
  dltq_res_if.source res
);
  logic job_valid, job_ready;
  job_t job;
  res_t r;

  // The front part screens each command beat and parks it in a two-deep job
  // queue, so command beats keep coming while the back part walks the list.
  dltq_front u_front (
    .clk, .rst, .cmd, .job_valid, .job_ready, .job
  );

  // The back part owns the pool, the list head and the elapsed count. It
  // decides a full pool itself, because earlier jobs may still free entries.
  dltq_back #(.POOL_ENTRIES(POOL_ENTRIES)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .res_valid(res.valid), .res_ready(res.ready), .res(r)
  );

  // The result register in the back part drives the result beat directly.
  assign res.status = r.status;
  assign res.fired = r.fired;
  assign res.fired_handle = r.fired_handle;
  assign res.fired_tag = r.fired_tag;

`ifndef SYNTHESIS
  // A beat that did not fire carries zero handle and tag.
  a_nofire_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.fired |-> res.fired_handle == '0 && res.fired_tag == '0)
    else $error("unfired result carries data");
  // A firing result always reports ok status.
  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.fired |-> res.status == ST_OK)
    else $error("fired result with error status");
`endif
endmodule

>>> tb/tb_delta_list_timer_queue.sv
// Testbench for the delta-list timer queue: random and directed commands checked against a model.
module tb_delta_list_timer_queue;
  import dltq_pkg::*;

  localparam int POOL = 16;
  localparam int NIL = POOL;
  localparam logic [16:0] CNT_MASK = 17'h1FFFF;
  localparam int CYCLE_LIMIT = 400000;

  // One command beat as the sender sees it.
  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [PERIOD_W-1:0] period;
    logic                one_shot;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
  } timer_cmd_t;

  // Timer list model plus the queue of outcomes still owed by the block.
  class timer_scoreboard;
    logic [16:0]         delta [POOL];
    logic [PERIOD_W-1:0] period [POOL];
    logic [HANDLE_W-1:0] handle [POOL];
    logic [TAG_W-1:0]    tag [POOL];
    logic                one_shot [POOL];
    int                  link [POOL];
    logic                in_use [POOL];
    int                  head;
    logic [16:0]         count;
    res_t                owed [$];
    int                  mismatches;
    int                  checked;
    int                  fires;

    function new();
      head = NIL;
      count = '0;
      mismatches = 0;
      checked = 0;
      fires = 0;
      for (int i = 0; i < POOL; i++) begin
        in_use[i] = 1'b0;
        delta[i] = '0;
        link[i] = NIL;
      end
    endfunction

    function int listed();
      int n;
      n = 0;
      for (int i = 0; i < POOL; i++) n += in_use[i];
      return n;
    endfunction

    // Insert a slot at absolute time per + count, behind equal due times.
    function void insert_slot(int slot, logic [PERIOD_W-1:0] per);
      logic [16:0] due, acc, rel;
      int prev, p, steps;
      due = (17'(per) + count) & CNT_MASK;
      acc = '0;
      prev = NIL;
      p = head;
      steps = 0;
      while (p < NIL && steps < POOL && (18'(acc) + 18'(delta[p])) <= 18'(due)) begin
        acc += delta[p];
        prev = p;
        p = link[p];
        steps++;
      end
      rel = due - acc;
      delta[slot] = rel;
      link[slot] = p;
      if (p < NIL) delta[p] = delta[p] - rel;
      if (prev < NIL) link[prev] = slot;
      else head = slot;
    endfunction

    function logic [STATUS_W-1:0] add_timer(timer_cmd_t c);
      int slot;
      if (c.period == 0) return ST_ZERO_PERIOD;
      slot = NIL;
      for (int i = POOL - 1; i >= 0; i--) if (!in_use[i]) slot = i;
      if (slot == NIL) return ST_POOL_FULL;
      in_use[slot] = 1'b1;
      period[slot] = c.period;
      one_shot[slot] = c.one_shot;
      handle[slot] = c.handle;
      tag[slot] = c.tag;
      insert_slot(slot, c.period);
      return ST_OK;
    endfunction

    function logic [STATUS_W-1:0] remove_timer(logic [HANDLE_W-1:0] h);
      int prev, p, steps, nxt;
      prev = NIL;
      p = head;
      steps = 0;
      while (p < NIL && steps < POOL) begin
        if (handle[p] == h) break;
        prev = p;
        p = link[p];
        steps++;
      end
      if (p >= NIL || steps >= POOL) return ST_NOT_FOUND;
      nxt = link[p];
      if (prev >= NIL) begin
        // Removing the head keeps every later due time and restarts the count.
        head = nxt;
        if (nxt < NIL) delta[nxt] = delta[nxt] + delta[p] - count;
        count = '0;
      end else begin
        if (nxt < NIL) delta[nxt] = delta[nxt] + delta[p];
        link[prev] = nxt;
      end
      in_use[p] = 1'b0;
      return ST_OK;
    endfunction

    // Note an accepted command beat and queue the outcome it must produce.
    function void note_command(timer_cmd_t c);
      res_t r;
      int h;
      r = '0;
      if (c.command == CMD_ADD) r.status = add_timer(c);
      else if (c.command == CMD_REMOVE) r.status = remove_timer(c.handle);
      else if (c.command == CMD_TICK && head < NIL) begin
        h = head;
        count = count + 1'b1;
        if (count >= delta[h]) begin
          r.fired = 1'b1;
          r.fired_handle = handle[h];
          r.fired_tag = tag[h];
          head = link[h];
          count = '0;
          if (one_shot[h]) in_use[h] = 1'b0;
          else insert_slot(h, period[h]);
        end
      end
      owed.push_back(r);
    endfunction

    // Compare one result beat with the oldest outstanding outcome.
    function void check_result(res_t got);
      res_t want;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
        return;
      end
      want = owed.pop_front();
      if (want.fired) fires++;
      if (got.status !== want.status || got.fired !== want.fired ||
          got.fired_handle !== want.fired_handle || got.fired_tag !== want.fired_tag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected st=%0d f=%0b h=%0d t=%0d got st=%0d f=%0b h=%0d t=%0d",
                   checked, want.status, want.fired, want.fired_handle, want.fired_tag,
                   got.status, got.fired, got.fired_handle, got.fired_tag);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  dltq_cmd_if cmd_ch ();
  dltq_res_if res_ch ();

  delta_list_timer_queue #(.POOL_ENTRIES(POOL)) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch.sink),
    .res(res_ch.source)
  );

  timer_scoreboard board = new();
  int unsigned cycles = 0;
  int sent = 0;
  // While set, the result side stops accepting beats for a long stretch.
  bit hold_results = 1'b0;
  bit stim_done = 1'b0;
  // Handles are drawn from a small set so removes usually find their timer.
  logic [HANDLE_W-1:0] live_handles [$];

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_NOP;
    cmd_ch.period_ticks = '0;
    cmd_ch.one_shot = 1'b0;
    cmd_ch.timer_handle = '0;
    cmd_ch.callback_tag = '0;
    res_ch.ready = 1'b0;
  end

  // The watchdog covers about 950 beats plus idle gaps on both sides and one
  // long receiver stall, several times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycles, board.owed.size());
      $display("tb_delta_list_timer_queue: FAIL");
      $finish;
    end
  end

  // Result beats are sampled at the edge where valid and ready are both high.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      board.check_result('{res_ch.status, res_ch.fired, res_ch.fired_handle, res_ch.fired_tag});
  end

  // Receiver: a random stall before each beat, except when held off.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (stim_done) gap = 0;
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        res_ch.ready <= 1'b1;
        @(posedge clk);
        while (!(res_ch.valid && res_ch.ready) && !hold_results) @(posedge clk);
      end
    end
  end

  // Offer one command beat after a gap and wait until it is accepted.
  // Valid stays high straight into the next beat when there is no gap.
  task automatic send_command(timer_cmd_t c, int gap);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= c.command;
    cmd_ch.period_ticks <= c.period;
    cmd_ch.one_shot <= c.one_shot;
    cmd_ch.timer_handle <= c.handle;
    cmd_ch.callback_tag <= c.tag;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    board.note_command(c);
    sent++;
  endtask

  task automatic send_drawn(timer_cmd_t c);
    int gap;
    gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
    send_command(c, gap);
  endtask

  function automatic timer_cmd_t make_cmd(logic [CMD_W-1:0] op, logic [PERIOD_W-1:0] per,
                                          logic os, logic [HANDLE_W-1:0] h,
                                          logic [TAG_W-1:0] t);
    timer_cmd_t c;
    c.command = op;
    c.period = per;
    c.one_shot = os;
    c.handle = h;
    c.tag = t;
    return c;
  endfunction

  // Mostly short periods so timers really expire under ticks; now and then
  // a period anywhere in the full 16-bit range.
  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int roll;
    logic [PERIOD_W-1:0] per;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: per = PERIOD_W'($urandom());
      1: per = '0;
      default: per = PERIOD_W'($urandom_range(1, 12));
    endcase
    c = make_cmd(CMD_TICK, per, 1'($urandom_range(0, 1)), HANDLE_W'($urandom_range(0, 15)),
                 TAG_W'($urandom()));
    if ($urandom_range(0, 15) == 0) c.handle = HANDLE_W'($urandom());
    if (roll < 30) c.command = CMD_ADD;
    else if (roll < 42) begin
      c.command = CMD_REMOVE;
      if (live_handles.size() > 0 && $urandom_range(0, 3) != 0)
        c.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
    end else if (roll < 97) c.command = CMD_TICK;
    else c.command = CMD_NOP;
    if (c.command == CMD_ADD) live_handles.push_back(c.handle);
    if (live_handles.size() > 24) void'(live_handles.pop_front());
    return c;
  endfunction

  initial begin
    timer_cmd_t c;
    int waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty-queue tick and remove, zero period, field extremes,
    // a full pool, equal due times, head removal and a periodic re-add.
    send_drawn(make_cmd(CMD_TICK, 16'd0, 1'b0, 8'd0, 16'd0));
    send_drawn(make_cmd(CMD_REMOVE, 16'd0, 1'b0, 8'hFF, 16'd0));
    send_drawn(make_cmd(CMD_ADD, 16'd0, 1'b1, 8'd1, 16'hFFFF));
    send_drawn(make_cmd(CMD_NOP, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF));
    send_drawn(make_cmd(CMD_ADD, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF));
    for (int i = 0; i < 15; i++)
      send_drawn(make_cmd(CMD_ADD, 16'(1 + i / 3), i[0], 8'(i), 16'(16'hA000 + i)));
    // The pool is full now: one more add must be refused.
    send_drawn(make_cmd(CMD_ADD, 16'd1, 1'b0, 8'd77, 16'h1234));
    send_drawn(make_cmd(CMD_TICK, 16'd0, 1'b0, 8'd0, 16'd0));
    send_drawn(make_cmd(CMD_REMOVE, 16'd0, 1'b0, 8'd4, 16'd0));
    send_drawn(make_cmd(CMD_REMOVE, 16'd0, 1'b0, 8'hFF, 16'd0));
    send_drawn(make_cmd(CMD_TICK, 16'd0, 1'b0, 8'd0, 16'd0));

    // Pause the sender until every outstanding result has come back.
    cmd_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);

    // Drain the long timers and the full pool so random traffic starts lean.
    for (int h = 0; h < 16; h++)
      send_drawn(make_cmd(CMD_REMOVE, 16'd0, 1'b0, 8'(h), 16'd0));
    send_drawn(make_cmd(CMD_REMOVE, 16'd0, 1'b0, 8'hFF, 16'd0));
    send_drawn(make_cmd(CMD_REMOVE, 16'd0, 1'b0, 8'd1, 16'd0));

    // Random part with a long receiver stall partway through, so the job
    // queue fills and the block stops taking command beats.
    for (int n = 0; n < 910; n++) begin
      if (n == 300) hold_results = 1'b1;
      if (n == 300) fork
        begin
          repeat (400) @(posedge clk);
          hold_results = 1'b0;
        end
      join_none
      c = random_cmd();
      if (n % 200 < 40) send_command(c, 0);
      else send_drawn(c);
    end
    cmd_ch.valid <= 1'b0;
    stim_done = 1'b1;

    waited = 0;
    while (board.owed.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    $display("Sent %0d command beats, checked %0d result beats, %0d timer expirations.",
             sent, board.checked, board.fires);
    $display("Pool at end holds %0d timers; %0d mismatches.", board.listed(), board.mismatches);
    if (board.mismatches == 0 && board.owed.size() == 0)
      $display("tb_delta_list_timer_queue: PASS");
    else begin
      if (board.owed.size() != 0) $display("ERROR: %0d results never arrived", board.owed.size());
      $display("tb_delta_list_timer_queue: FAIL");
    end
    $finish;
  end
endmodule
